/* hdl/sle_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sle_pkg: shared types and constants of the serial line editor
// Holds the line store geometry, the character codes, the echo codes and
// the command and status groups between controller and datapath.
// ---------------------------------------------------------------------------
package sle_pkg;

    localparam int LINE_MAX = 64;
    localparam int ADDR_W   = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
    localparam int CNT_W    = 7;

    localparam logic [7:0] CH_BS  = 8'd8;
    localparam logic [7:0] CH_NL  = 8'd10;
    localparam logic [7:0] CH_CTK = 8'd11;
    localparam logic [7:0] CH_CTU = 8'd21;
    localparam logic [7:0] CH_ESC = 8'd27;
    localparam logic [7:0] CH_LBR = 8'h5B;
    localparam logic [7:0] CH_C   = 8'h43;
    localparam logic [7:0] CH_D   = 8'h44;
    localparam logic [7:0] CH_DEL = 8'd127;

    localparam logic [1:0] ECHO_NONE = 2'd0;
    localparam logic [1:0] ECHO_BS   = 2'd1;
    localparam logic [1:0] ECHO_SOL  = 2'd2;
    localparam logic [1:0] ECHO_EOL  = 2'd3;

    typedef enum logic [1:0] {
        OP_SIMPLE = 2'd0,
        OP_DOWN   = 2'd1,
        OP_UP     = 2'd2,
        OP_NL     = 2'd3
    } sle_op_t;

    typedef struct packed {
        logic load;
        logic decide;
        logic rd;
        logic wr;
        logic fin;
        logic emit_status;
        logic emit_byte;
    } sle_cmd_t;

    typedef struct packed {
        sle_op_t op;
        logic    nl_empty;
        logic    walk_done;
        logic    last_byte;
        logic    out_free;
    } sle_sts_t;

endpackage

/* hdl/sle_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sle_ctrl: sequencer of the serial line editor
// Steps each item through decode, the shift walk over the store, the
// newline read-out and the delivery of the status result.
// ---------------------------------------------------------------------------
module sle_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sle_pkg::sle_sts_t sts,
    output sle_pkg::sle_cmd_t cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECIDE = 8'b0000_0010,
        S_RD     = 8'b0000_0100,
        S_WR     = 8'b0000_1000,
        S_FIN    = 8'b0001_0000,
        S_EMIT   = 8'b0010_0000,
        S_NRD    = 8'b0100_0000,
        S_NOUT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                unique case (sts.op)
                    sle_pkg::OP_SIMPLE: state_next = S_EMIT;
                    sle_pkg::OP_DOWN:   state_next = S_RD;
                    sle_pkg::OP_UP:     state_next = S_RD;
                    sle_pkg::OP_NL:     state_next = sts.nl_empty ? S_EMIT : S_NRD;
                    default:            state_next = S_EMIT;
                endcase
            end
            S_RD:
            begin
                if (sts.walk_done)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_WR;
                end
            end
            S_WR:
            begin
                cmd.wr     = 1'b1;
                state_next = S_RD;
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_status = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_NRD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_NOUT;
            end
            S_NOUT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_byte = 1'b1;
                    state_next    = sts.last_byte ? S_IDLE : S_NRD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_status || cmd.emit_byte) |-> sts.out_free)
        else $error("result loaded while output register is busy");
    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr |-> $past(cmd.rd))
        else $error("store write without a preceding read");
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state is not one-hot");
`endif

endmodule

/* hdl/sle_datapath.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sle_datapath: line store, cursor and output register of the line editor
// Decodes the held character, moves store bytes one per walk step and
// holds the result item until the consumer takes it.
// ---------------------------------------------------------------------------
module sle_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  sle_pkg::sle_cmd_t cmd,
    output sle_pkg::sle_sts_t sts,
    input  logic [7:0]        char_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              result_kind,
    output logic [7:0]        line_byte,
    output logic              last,
    output logic              empty_line,
    output logic [6:0]        out_cursor,
    output logic [6:0]        out_length,
    output logic [1:0]        echo_action,
    output logic              overflow
);

    localparam int AW = sle_pkg::ADDR_W;
    localparam int CW = sle_pkg::CNT_W;

    logic [7:0] mem [sle_pkg::LINE_MAX];

    logic [CW-1:0] len_reg, len_next;
    logic [CW-1:0] cur_reg, cur_next;
    logic          esc_reg, esc_next;
    logic          csi_reg, csi_next;
    logic          oval_reg, oval_next;
    logic [7:0]    char_reg, char_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] dist_reg, dist_next;
    logic          up_reg, up_next;
    logic [1:0]    echo_reg, echo_next;
    logic          ovf_reg, ovf_next;
    logic          empty_reg, empty_next;
    logic [7:0]    rdata_reg;

    logic          okind_reg, okind_next;
    logic [7:0]    obyte_reg, obyte_next;
    logic          olast_reg, olast_next;
    logic          oempty_reg, oempty_next;
    logic [6:0]    ocur_reg, ocur_next;
    logic [6:0]    olen_reg, olen_next;
    logic [1:0]    oecho_reg, oecho_next;
    logic          oovf_reg, oovf_next;

    logic          is_bs, is_del, is_ctu, is_ctk, is_nl, full;
    sle_pkg::sle_op_t op;
    logic [CW-1:0] rd_ptr, wr_ptr;
    logic          mem_we;
    logic [7:0]    mem_wdata;

    assign is_bs  = (char_reg == sle_pkg::CH_BS);
    assign is_del = (char_reg == sle_pkg::CH_DEL);
    assign is_ctu = (char_reg == sle_pkg::CH_CTU);
    assign is_ctk = (char_reg == sle_pkg::CH_CTK);
    assign is_nl  = (char_reg == sle_pkg::CH_NL);
    assign full   = (len_reg >= CW'(sle_pkg::LINE_MAX));

    always_comb
    begin
        priority if (csi_reg)
            op = sle_pkg::OP_SIMPLE;
        else if (char_reg == sle_pkg::CH_LBR && esc_reg)
            op = sle_pkg::OP_SIMPLE;
        else if (char_reg == sle_pkg::CH_ESC)
            op = sle_pkg::OP_SIMPLE;
        else if (is_bs || is_del || is_ctu)
            op = (cur_reg != '0) ? sle_pkg::OP_DOWN : sle_pkg::OP_SIMPLE;
        else if (is_ctk)
            op = sle_pkg::OP_SIMPLE;
        else if (is_nl)
            op = sle_pkg::OP_NL;
        else
            op = full ? sle_pkg::OP_SIMPLE : sle_pkg::OP_UP;
    end

    assign sts.op        = op;
    assign sts.nl_empty  = (len_reg == '0);
    assign sts.walk_done = up_reg ? (ptr_reg == cur_reg) : (ptr_reg == len_reg);
    assign sts.last_byte = ((ptr_reg + CW'(1)) == len_reg);
    assign sts.out_free  = !oval_reg || out_ready;

    // Upward walks read the byte below the target; downward walks read the
    // source and write it dist places lower.
    assign rd_ptr    = up_reg ? (ptr_reg - CW'(1)) : ptr_reg;
    assign wr_ptr    = cmd.fin ? cur_reg : (up_reg ? ptr_reg : (ptr_reg - dist_reg));
    assign mem_we    = cmd.wr || (cmd.fin && up_reg);
    assign mem_wdata = cmd.fin ? char_reg : rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_ptr[AW-1:0]] <= mem_wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[rd_ptr[AW-1:0]];
        end
    end

    always_comb
    begin
        len_next    = len_reg;
        cur_next    = cur_reg;
        esc_next    = esc_reg;
        csi_next    = csi_reg;
        oval_next   = oval_reg;
        char_next   = char_reg;
        ptr_next    = ptr_reg;
        dist_next   = dist_reg;
        up_next     = up_reg;
        echo_next   = echo_reg;
        ovf_next    = ovf_reg;
        empty_next  = empty_reg;
        okind_next  = okind_reg;
        obyte_next  = obyte_reg;
        olast_next  = olast_reg;
        oempty_next = oempty_reg;
        ocur_next   = ocur_reg;
        olen_next   = olen_reg;
        oecho_next  = oecho_reg;
        oovf_next   = oovf_reg;

        if (cmd.load)
        begin
            char_next = char_in;
        end

        if (cmd.decide)
        begin
            echo_next  = sle_pkg::ECHO_NONE;
            ovf_next   = 1'b0;
            empty_next = 1'b0;
            priority if (csi_reg)
            begin
                if (char_reg == sle_pkg::CH_C && cur_reg < len_reg)
                    cur_next = cur_reg + CW'(1);
                else if (char_reg == sle_pkg::CH_D && cur_reg != '0)
                    cur_next = cur_reg - CW'(1);
                csi_next = 1'b0;
            end
            else if (char_reg == sle_pkg::CH_LBR && esc_reg)
            begin
                esc_next = 1'b0;
                csi_next = 1'b1;
            end
            else if (char_reg == sle_pkg::CH_ESC)
            begin
                esc_next = 1'b1;
            end
            else
            begin
                esc_next = 1'b0;
                priority if (is_bs || is_del || is_ctu)
                begin
                    ptr_next  = cur_reg;
                    up_next   = 1'b0;
                    dist_next = is_ctu ? cur_reg : CW'(1);
                end
                else if (is_ctk)
                begin
                    if (cur_reg < len_reg)
                    begin
                        len_next  = cur_reg;
                        echo_next = sle_pkg::ECHO_EOL;
                    end
                end
                else if (is_nl)
                begin
                    ptr_next   = '0;
                    up_next    = 1'b0;
                    empty_next = (len_reg == '0);
                end
                else if (full)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    ptr_next = len_reg;
                    up_next  = 1'b1;
                end
            end
        end

        if (cmd.wr)
        begin
            ptr_next = up_reg ? (ptr_reg - CW'(1)) : (ptr_reg + CW'(1));
        end

        if (cmd.fin)
        begin
            priority if (up_reg)
            begin
                cur_next = cur_reg + CW'(1);
                len_next = len_reg + CW'(1);
            end
            else if (is_ctu)
            begin
                len_next  = len_reg - cur_reg;
                cur_next  = '0;
                echo_next = sle_pkg::ECHO_SOL;
            end
            else
            begin
                cur_next  = cur_reg - CW'(1);
                len_next  = len_reg - CW'(1);
                echo_next = is_del ? sle_pkg::ECHO_BS : sle_pkg::ECHO_NONE;
            end
        end

        if (oval_reg && out_ready)
        begin
            oval_next = 1'b0;
        end

        if (cmd.emit_status)
        begin
            oval_next   = 1'b1;
            okind_next  = 1'b0;
            obyte_next  = 8'd0;
            olast_next  = 1'b1;
            oempty_next = empty_reg;
            ocur_next   = cur_reg;
            olen_next   = len_reg;
            oecho_next  = echo_reg;
            oovf_next   = ovf_reg;
        end

        if (cmd.emit_byte)
        begin
            oval_next   = 1'b1;
            okind_next  = 1'b1;
            obyte_next  = rdata_reg;
            olast_next  = sts.last_byte;
            oempty_next = 1'b0;
            ocur_next   = 7'd0;
            olen_next   = 7'd0;
            oecho_next  = sle_pkg::ECHO_NONE;
            oovf_next   = 1'b0;
            ptr_next    = ptr_reg + CW'(1);
            if (sts.last_byte)
            begin
                len_next = '0;
                cur_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            cur_reg  <= '0;
            esc_reg  <= 1'b0;
            csi_reg  <= 1'b0;
            oval_reg <= 1'b0;
        end
        else
        begin
            len_reg  <= len_next;
            cur_reg  <= cur_next;
            esc_reg  <= esc_next;
            csi_reg  <= csi_next;
            oval_reg <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg   <= char_next;
        ptr_reg    <= ptr_next;
        dist_reg   <= dist_next;
        up_reg     <= up_next;
        echo_reg   <= echo_next;
        ovf_reg    <= ovf_next;
        empty_reg  <= empty_next;
        okind_reg  <= okind_next;
        obyte_reg  <= obyte_next;
        olast_reg  <= olast_next;
        oempty_reg <= oempty_next;
        ocur_reg   <= ocur_next;
        olen_reg   <= olen_next;
        oecho_reg  <= oecho_next;
        oovf_reg   <= oovf_next;
    end

    assign out_valid   = oval_reg;
    assign result_kind = okind_reg;
    assign line_byte   = obyte_reg;
    assign last        = olast_reg;
    assign empty_line  = oempty_reg;
    assign out_cursor  = ocur_reg;
    assign out_length  = olen_reg;
    assign echo_action = oecho_reg;
    assign overflow    = oovf_reg;

`ifndef SYNTHESIS
    a_cur_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg <= len_reg)
        else $error("cursor beyond line end");
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= CW'(sle_pkg::LINE_MAX))
        else $error("line length beyond store size");
    a_esc_csi: assert property (@(posedge clk) disable iff (!rst_n)
        !(esc_reg && csi_reg))
        else $error("escape and sequence flags both set");
`endif

endmodule

/* hdl/serial_line_editor.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// serial_line_editor: line editor with cursor keys for a serial console
// Takes one received character per item, edits a bounded line store and
// returns a status item, or the bytes of the completed line on newline.
// ---------------------------------------------------------------------------
// Sequence: a key that moves no store bytes goes from decode to the status
// step; an insert or delete adds a read and a write step for each byte that
// the shift walk moves, plus a finishing step; a newline reads each byte
// before it gives it out. Items are taken one at a time, and the shift walk
// over the store sets the worst case; a busy output register stalls both.
// Reset clears length, cursor and escape state; the store needs no clearing.
// ---------------------------------------------------------------------------
module serial_line_editor (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       result_kind,
    output logic [7:0] line_byte,
    output logic       last,
    output logic       empty_line,
    output logic [6:0] out_cursor,
    output logic [6:0] out_length,
    output logic [1:0] echo_action,
    output logic       overflow
);

    // The controller holds the state and decides the sequence of steps; the
    // datapath holds every other stored value, including the output register
    // that lets the next item be taken while a result still waits for the consumer.
    sle_pkg::sle_cmd_t cmd;
    sle_pkg::sle_sts_t sts;

    sle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sle_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .char_in     (char_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .line_byte   (line_byte),
        .last        (last),
        .empty_line  (empty_line),
        .out_cursor  (out_cursor),
        .out_length  (out_length),
        .echo_action (echo_action),
        .overflow    (overflow)
    );

endmodule
